FILE: src/ppb_pkg.sv
package ppb_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic [1:0]         status_t;

  localparam status_t ST_TWO      = 2'd0;
  localparam status_t ST_FLAT     = 2'd1;
  localparam status_t ST_NEG_DISC = 2'd2;
  localparam status_t ST_ON_SWEEP = 2'd3;

  // radicand d1*d2*(dx^2+e^2) < 2^130, root < 2^65
  localparam int RAD_W    = 130;
  localparam int ROOT_W   = 65;
  localparam int SQ_N     = RAD_W / 2;
  localparam int SQ_REM_W = 68;
  // numerator d1*dx +/- root fits 66 magnitude bits
  localparam int NUM_W    = 66;
  localparam int DIV_N    = NUM_W;
  localparam int QM_W     = 34;
  localparam logic [NUM_W:0] Q_CAP = (NUM_W + 1)'(1) << 33;

  typedef struct packed {
    logic        vld;
    status_t     st;
    coord_t      x1;
    logic        eneg;
    logic [31:0] emag;
    logic        mneg;
    logic [63:0] m;
  } side_t;

endpackage

FILE: src/parabola_pair_breakpoints_core.sv
// Channel   Direction  Handshake             Payload
// command   in         start (busy low)      focus_one_x, focus_two_x, focus_one_y,
//                                            focus_two_y, sweep_height
// result    out        strobe, one cycle     status, left_x, right_x, saturated
//
// One item enters every cycle.
// Most of the pipeline is the square root (one root bit per stage, 65 stages) and
// the two dividers that follow it (one quotient bit per stage, 66 stages).
// busy is never raised: the pipeline always advances and the receiver cannot stall.
// Synchronous reset clears the valid bits only; no result is shown until an item
// has run the full length.
module parabola_pair_breakpoints_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ppb_pkg::coord_t  focus_one_x,
  input  ppb_pkg::coord_t  focus_two_x,
  input  ppb_pkg::coord_t  focus_one_y,
  input  ppb_pkg::coord_t  focus_two_y,
  input  ppb_pkg::coord_t  sweep_height,
  output logic             strobe,
  output ppb_pkg::status_t status,
  output ppb_pkg::coord_t  left_x,
  output ppb_pkg::coord_t  right_x,
  output logic             saturated
);
  import ppb_pkg::*;

  assign busy = 1'b0;

  // stage 1: differences
  logic               v1;
  coord_t             x1_1;
  logic signed [32:0] d1_1, d2_1, dx_1, e_1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    x1_1 <= focus_one_x;
    d1_1 <= 33'(focus_one_y) - 33'(sweep_height);
    d2_1 <= 33'(focus_two_y) - 33'(sweep_height);
    dx_1 <= 33'(focus_two_x) - 33'(focus_one_x);
    e_1  <= 33'(focus_one_y) - 33'(focus_two_y);
  end

  // stage 2: status and magnitudes
  logic        v2, mneg2, eneg2;
  status_t     st2;
  coord_t      x1_2;
  logic [31:0] md1_2, md2_2, mdx_2, me_2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    x1_2  <= x1_1;
    if (e_1 == '0)                         st2 <= ST_FLAT;
    else if (d1_1 == '0 || d2_1 == '0)     st2 <= ST_ON_SWEEP;
    else if (d1_1[32] != d2_1[32])         st2 <= ST_NEG_DISC;
    else                                   st2 <= ST_TWO;
    mneg2 <= d1_1[32] ^ dx_1[32];
    eneg2 <= e_1[32];
    md1_2 <= d1_1[32] ? 32'(-d1_1) : d1_1[31:0];
    md2_2 <= d2_1[32] ? 32'(-d2_1) : d2_1[31:0];
    mdx_2 <= dx_1[32] ? 32'(-dx_1) : dx_1[31:0];
    me_2  <= e_1[32]  ? 32'(-e_1)  : e_1[31:0];
  end

  // stage 3: squares and products
  side_t       sd3;
  logic [63:0] pd3, pdx3, pe3;

  always_ff @(posedge clk) begin
    if (rst) sd3.vld <= 1'b0;
    else     sd3.vld <= v2;
    sd3.st   <= st2;
    sd3.x1   <= x1_2;
    sd3.eneg <= eneg2;
    sd3.emag <= me_2;
    sd3.mneg <= mneg2;
    sd3.m    <= md1_2 * mdx_2;
    pd3      <= md1_2 * md2_2;
    pdx3     <= mdx_2 * mdx_2;
    pe3      <= me_2 * me_2;
  end

  // stage 4: dx^2 + e^2
  side_t       sd4;
  logic [63:0] pd4;
  logic [64:0] sq4;

  always_ff @(posedge clk) begin
    if (rst) sd4.vld <= 1'b0;
    else     sd4.vld <= sd3.vld;
    sd4.st   <= sd3.st;
    sd4.x1   <= sd3.x1;
    sd4.eneg <= sd3.eneg;
    sd4.emag <= sd3.emag;
    sd4.mneg <= sd3.mneg;
    sd4.m    <= sd3.m;
    pd4      <= pd3;
    sq4      <= 65'(pdx3) + 65'(pe3);
  end

  // stage 5: partial products of the radicand
  side_t       sd5;
  logic [63:0] pp00, pp10;
  logic [64:0] pp01, pp11;

  always_ff @(posedge clk) begin
    if (rst) sd5.vld <= 1'b0;
    else     sd5.vld <= sd4.vld;
    sd5.st   <= sd4.st;
    sd5.x1   <= sd4.x1;
    sd5.eneg <= sd4.eneg;
    sd5.emag <= sd4.emag;
    sd5.mneg <= sd4.mneg;
    sd5.m    <= sd4.m;
    pp00 <= pd4[31:0] * sq4[31:0];
    pp01 <= 65'(pd4[31:0] * sq4[64:32]);
    pp10 <= pd4[63:32] * sq4[31:0];
    pp11 <= 65'(pd4[63:32] * sq4[64:32]);
  end

  // stage 6: middle sum
  side_t       sd6;
  logic [63:0] pp00_6;
  logic [64:0] pp11_6;
  logic [65:0] mid6;

  always_ff @(posedge clk) begin
    if (rst) sd6.vld <= 1'b0;
    else     sd6.vld <= sd5.vld;
    sd6.st   <= sd5.st;
    sd6.x1   <= sd5.x1;
    sd6.eneg <= sd5.eneg;
    sd6.emag <= sd5.emag;
    sd6.mneg <= sd5.mneg;
    sd6.m    <= sd5.m;
    pp00_6 <= pp00;
    pp11_6 <= pp11;
    mid6   <= 66'(pp01) + 66'(pp10);
  end

  // square root: one result bit per stage
  side_t                sq_sd   [0:SQ_N];
  logic [RAD_W-1:0]     sq_rad  [0:SQ_N];
  logic [SQ_REM_W-1:0]  sq_rem  [0:SQ_N];
  logic [ROOT_W-1:0]    sq_root [0:SQ_N];
  logic [RAD_W-1:0]     sq_rad_next  [0:SQ_N-1];
  logic [SQ_REM_W-1:0]  sq_rem_next  [0:SQ_N-1];
  logic [ROOT_W-1:0]    sq_root_next [0:SQ_N-1];

  always_ff @(posedge clk) begin
    if (rst) sq_sd[0].vld <= 1'b0;
    else     sq_sd[0].vld <= sd6.vld;
    sq_sd[0].st   <= sd6.st;
    sq_sd[0].x1   <= sd6.x1;
    sq_sd[0].eneg <= sd6.eneg;
    sq_sd[0].emag <= sd6.emag;
    sq_sd[0].mneg <= sd6.mneg;
    sq_sd[0].m    <= sd6.m;
    sq_rad[0]  <= {pp11_6, pp00_6} + (RAD_W'(mid6) << 32);
    sq_rem[0]  <= '0;
    sq_root[0] <= '0;
  end

  always_comb begin : sq_step
    logic [SQ_REM_W+1:0] trial, tsub;
    for (int k = 0; k < SQ_N; k++) begin
      trial = {sq_rem[k], sq_rad[k][RAD_W-1 -: 2]};
      tsub  = {3'b000, sq_root[k], 2'b01};
      sq_rad_next[k] = sq_rad[k] << 2;
      if (trial >= tsub) begin
        sq_rem_next[k]  = SQ_REM_W'(trial - tsub);
        sq_root_next[k] = {sq_root[k][ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_next[k]  = trial[SQ_REM_W-1:0];
        sq_root_next[k] = {sq_root[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQ_N; k++) begin
      if (rst) sq_sd[k+1].vld <= 1'b0;
      else     sq_sd[k+1].vld <= sq_sd[k].vld;
      sq_sd[k+1].st   <= sq_sd[k].st;
      sq_sd[k+1].x1   <= sq_sd[k].x1;
      sq_sd[k+1].eneg <= sq_sd[k].eneg;
      sq_sd[k+1].emag <= sq_sd[k].emag;
      sq_sd[k+1].mneg <= sq_sd[k].mneg;
      sq_sd[k+1].m    <= sq_sd[k].m;
      sq_rad[k+1]  <= sq_rad_next[k];
      sq_rem[k+1]  <= sq_rem_next[k];
      sq_root[k+1] <= sq_root_next[k];
    end
  end

  // numerators d1*dx + root and d1*dx - root
  side_t              sdn;
  logic signed [66:0] npos, nneg;
  logic signed [66:0] mval;

  assign mval = sq_sd[SQ_N].mneg ? -$signed({3'b000, sq_sd[SQ_N].m})
                                 :  $signed({3'b000, sq_sd[SQ_N].m});

  always_ff @(posedge clk) begin
    if (rst) sdn.vld <= 1'b0;
    else     sdn.vld <= sq_sd[SQ_N].vld;
    sdn.st   <= sq_sd[SQ_N].st;
    sdn.x1   <= sq_sd[SQ_N].x1;
    sdn.eneg <= sq_sd[SQ_N].eneg;
    sdn.emag <= sq_sd[SQ_N].emag;
    sdn.mneg <= sq_sd[SQ_N].mneg;
    sdn.m    <= sq_sd[SQ_N].m;
    npos <= mval + $signed({2'b00, sq_root[SQ_N]});
    nneg <= mval - $signed({2'b00, sq_root[SQ_N]});
  end

  // two dividers sharing the divisor |e|: one quotient bit per stage
  side_t             dv_sd  [0:DIV_N];
  logic [NUM_W-1:0]  dv_num [0:DIV_N][0:1];
  logic [31:0]       dv_rem [0:DIV_N][0:1];
  logic              dv_neg [0:DIV_N][0:1];
  logic [NUM_W-1:0]  dv_num_next [0:DIV_N-1][0:1];
  logic [31:0]       dv_rem_next [0:DIV_N-1][0:1];

  always_ff @(posedge clk) begin
    if (rst) dv_sd[0].vld <= 1'b0;
    else     dv_sd[0].vld <= sdn.vld;
    dv_sd[0].st   <= sdn.st;
    dv_sd[0].x1   <= sdn.x1;
    dv_sd[0].eneg <= sdn.eneg;
    dv_sd[0].emag <= sdn.emag;
    dv_sd[0].mneg <= sdn.mneg;
    dv_sd[0].m    <= sdn.m;
    dv_num[0][0] <= npos[66] ? NUM_W'(-npos) : npos[NUM_W-1:0];
    dv_num[0][1] <= nneg[66] ? NUM_W'(-nneg) : nneg[NUM_W-1:0];
    dv_neg[0][0] <= npos[66] ^ sdn.eneg;
    dv_neg[0][1] <= nneg[66] ^ sdn.eneg;
    dv_rem[0][0] <= '0;
    dv_rem[0][1] <= '0;
  end

  always_comb begin : dv_step
    logic [32:0] trial;
    for (int k = 0; k < DIV_N; k++) begin
      for (int l = 0; l < 2; l++) begin
        trial = {dv_rem[k][l], dv_num[k][l][NUM_W-1]};
        if (trial >= {1'b0, dv_sd[k].emag}) begin
          dv_rem_next[k][l] = 32'(trial - {1'b0, dv_sd[k].emag});
          dv_num_next[k][l] = {dv_num[k][l][NUM_W-2:0], 1'b1};
        end else begin
          dv_rem_next[k][l] = trial[31:0];
          dv_num_next[k][l] = {dv_num[k][l][NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_N; k++) begin
      if (rst) dv_sd[k+1].vld <= 1'b0;
      else     dv_sd[k+1].vld <= dv_sd[k].vld;
      dv_sd[k+1].st   <= dv_sd[k].st;
      dv_sd[k+1].x1   <= dv_sd[k].x1;
      dv_sd[k+1].eneg <= dv_sd[k].eneg;
      dv_sd[k+1].emag <= dv_sd[k].emag;
      dv_sd[k+1].mneg <= dv_sd[k].mneg;
      dv_sd[k+1].m    <= dv_sd[k].m;
      for (int l = 0; l < 2; l++) begin
        dv_num[k+1][l] <= dv_num_next[k][l];
        dv_rem[k+1][l] <= dv_rem_next[k][l];
        dv_neg[k+1][l] <= dv_neg[k][l];
      end
    end
  end

  // round toward minus infinity and cap the quotient magnitude
  logic             vf1;
  status_t          stf1;
  coord_t           x1_f1;
  logic [QM_W-1:0]  qm_f1  [0:1];
  logic             neg_f1 [0:1];
  logic [NUM_W:0]   qround [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qround[l] = {1'b0, dv_num[DIV_N][l]}
                + (NUM_W + 1)'(dv_neg[DIV_N][l] && dv_rem[DIV_N][l] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vf1 <= 1'b0;
    else     vf1 <= dv_sd[DIV_N].vld;
    stf1  <= dv_sd[DIV_N].st;
    x1_f1 <= dv_sd[DIV_N].x1;
    for (int l = 0; l < 2; l++) begin
      qm_f1[l]  <= (qround[l] > Q_CAP) ? QM_W'(Q_CAP) : qround[l][QM_W-1:0];
      neg_f1[l] <= dv_neg[DIV_N][l];
    end
  end

  // add x1 and clamp to 32 bits
  logic               vf2;
  status_t            stf2;
  coord_t             xc_f2  [0:1];
  logic               sat_f2 [0:1];
  logic signed [34:0] xsum   [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      xsum[l] = neg_f1[l] ? 35'(x1_f1) - $signed({1'b0, qm_f1[l]})
                          : 35'(x1_f1) + $signed({1'b0, qm_f1[l]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vf2 <= 1'b0;
    else     vf2 <= vf1;
    stf2 <= stf1;
    for (int l = 0; l < 2; l++) begin
      if (xsum[l] > 35'sd2147483647) begin
        xc_f2[l]  <= 32'sh7FFF_FFFF;
        sat_f2[l] <= 1'b1;
      end else if (xsum[l] < -35'sd2147483648) begin
        xc_f2[l]  <= 32'sh8000_0000;
        sat_f2[l] <= 1'b1;
      end else begin
        xc_f2[l]  <= xsum[l][31:0];
        sat_f2[l] <= 1'b0;
      end
    end
  end

  // order, drop the values unless two crossings, present the item
  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= vf2;
    status <= stf2;
    if (stf2 != ST_TWO) begin
      left_x    <= '0;
      right_x   <= '0;
      saturated <= 1'b0;
    end else begin
      saturated <= sat_f2[0] | sat_f2[1];
      if (xc_f2[0] > xc_f2[1]) begin
        left_x  <= xc_f2[1];
        right_x <= xc_f2[0];
      end else begin
        left_x  <= xc_f2[0];
        right_x <= xc_f2[1];
      end
    end
  end

  a_ordered: assert property (@(posedge clk) disable iff (rst)
    strobe && status == ST_TWO |-> left_x <= right_x)
    else $error("crossings out of order");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    strobe && status != ST_TWO |-> left_x == '0 && right_x == '0 && !saturated)
    else $error("result fields not cleared for a degenerate item");

  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

  a_strobe_from_pipe: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(vf2))
    else $error("result without an item in the last stage");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import ppb_pkg::*;

  typedef struct {
    status_t st;
    coord_t  lx;
    coord_t  rx;
    logic    sat;
  } crossing_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  coord_t  focus_one_x = '0, focus_two_x = '0, focus_one_y = '0, focus_two_y = '0;
  coord_t  sweep_height = '0;
  logic    strobe;
  status_t status;
  coord_t  left_x, right_x;
  logic    saturated;

  crossing_t pending_q[$];
  int        fail_cnt = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        st_count[4] = '{0, 0, 0, 0};
  int        sat_count = 0;

  parabola_pair_breakpoints_core u_dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] isqrt_130(logic [129:0] p);
    logic [129:0] root, rem, t;
    root = '0;
    rem = '0;
    for (int i = 64; i >= 0; i--) begin
      rem = (rem << 2) | ((p >> (2 * i)) & 130'd3);
      t = (root << 2) | 130'd1;
      root = root << 1;
      if (rem >= t) begin
        rem = rem - t;
        root = root | 130'd1;
      end
    end
    return root[63:0];
  endfunction

  // x1 + floor(n / e), clamped to 32 bits
  function automatic coord_t cross_at(logic signed [71:0] n, logic signed [71:0] e,
                                      logic signed [71:0] x1, ref logic sat);
    logic signed [71:0] q, r, x;
    q = n / e;
    r = n % e;
    if (r != 0 && ((r < 0) != (e < 0))) q = q - 1;
    x = x1 + q;
    if (x > 72'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (x < -72'sh80000000) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic crossing_t predict_crossings(coord_t x1, coord_t x2, coord_t y1,
                                                  coord_t y2, coord_t sw);
    crossing_t c;
    logic signed [71:0] d1, d2, dx, e, m, s;
    logic [129:0] rad;
    logic sat;
    coord_t a, b;
    c = '{ST_TWO, '0, '0, 1'b0};
    d1 = y1 - sw;
    d2 = y2 - sw;
    dx = x2 - x1;
    e = y1 - y2;
    sat = 1'b0;
    if (e == 0) c.st = ST_FLAT;
    else if (d1 == 0 || d2 == 0) c.st = ST_ON_SWEEP;
    else if ((d1 < 0) != (d2 < 0)) c.st = ST_NEG_DISC;
    else begin
      rad = 130'(d1 * d2) * 130'(dx * dx + e * e);
      s = 72'(isqrt_130(rad));
      m = d1 * dx;
      a = cross_at(m + s, e, 72'(x1), sat);
      b = cross_at(m - s, e, 72'(x1), sat);
      c.lx = (a < b) ? a : b;
      c.rx = (a < b) ? b : a;
      c.sat = sat;
    end
    return c;
  endfunction

  // start stays high across back-to-back items; drop it only for a gap
  task automatic send_item(coord_t x1, coord_t x2, coord_t y1, coord_t y2, coord_t sw,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    focus_one_x <= x1;
    focus_two_x <= x2;
    focus_one_y <= y1;
    focus_two_y <= y2;
    sweep_height <= sw;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_crossings(x1, x2, y1, y2, sw));
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      crossing_t exp_c;
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: status %0d", status);
        fail_cnt++;
      end else begin
        exp_c = pending_q.pop_front();
        st_count[exp_c.st]++;
        if (exp_c.sat) sat_count++;
        if (status !== exp_c.st) begin
          $error("status expected %0d got %0d", exp_c.st, status);
          fail_cnt++;
        end
        if (left_x !== exp_c.lx) begin
          $error("left_x expected %0d got %0d", exp_c.lx, left_x);
          fail_cnt++;
        end
        if (right_x !== exp_c.rx) begin
          $error("right_x expected %0d got %0d", exp_c.rx, right_x);
          fail_cnt++;
        end
        if (saturated !== exp_c.sat) begin
          $error("saturated expected %0d got %0d", exp_c.sat, saturated);
          fail_cnt++;
        end
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $signed($urandom_range(0, 32'h0FFFFF)) - 32'sh80000;
      3: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 3)
                                     : 32'sh80000000 + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h1FFFFFF)) - 32'sh1000000;
    endcase
  endfunction

  task automatic test_directed();
    coord_t mx = 32'sh7FFFFFFF, mn = 32'sh80000000;
    send_item(0, 32'sh20000, 32'sh10000, 32'sh30000, 0, 0);
    send_item(5, 9, 32'sh10000, 32'sh10000, 0, 0);              // level foci
    send_item(0, 32'sh10000, 0, 32'sh10000, 0, 0);              // focus on sweep
    send_item(0, 32'sh10000, 32'sh10000, 32'sh20000, 32'sh10000, 1);
    send_item(0, 32'sh10000, 32'sh10000, -32'sh10000, 0, 0);    // opposite sides
    send_item(0, 32'sh10000, -32'sh10000, -32'sh30000, 0, 2);   // both below
    send_item(mn, mx, mx, mn + 1, 0, 0);
    send_item(mn, mx, mn, mx, 32'sh40000000, 0);
    send_item(mx, mn, mx, mx - 1, mn, 0);
    send_item(mn, mn, mn, mn + 1, mx, 0);
    send_item(mx, mx, 1, 2, 0, 0);
    send_item(mn, mx, 1, 2, 0, 0);
    send_item(0, 0, 32'sh10000, 32'sh20000, 0, 3);
    send_item(-1, 1, -1, -2, 0, 0);
    send_item(mx, mn, mn, mn + 1, mx, 0);
    send_item(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'h2AAAAAAA, 32'hAAAAAAAA, 0);
  endtask

  task automatic test_random(int n);
    coord_t x1, x2, y1, y2, sw;
    int gap;
    for (int i = 0; i < n; i++) begin
      x1 = rand_coord();
      x2 = rand_coord();
      y1 = rand_coord();
      y2 = rand_coord();
      sw = rand_coord();
      case ($urandom_range(0, 9))
        0: y2 = y1;
        1: sw = $urandom_range(0, 1) ? y1 : y2;
        default: ;
      endcase
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      send_item(x1, x2, y1, y2, sw, gap);
      if (i == n / 2) wait_drained();  // drain fully mid-run
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1500);
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d items, checked %0d results; status mix %0d/%0d/%0d/%0d, %0d clamped",
             items_sent, results_seen, st_count[0], st_count[1], st_count[2], st_count[3],
             sat_count);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("parabola_pair_breakpoints_core test passed");
    end else begin
      $display("parabola_pair_breakpoints_core test failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("parabola_pair_breakpoints_core test failed");
    $finish;
  end

endmodule
